[sv/pfd_pkg.sv]
package pfd_pkg;

    localparam int FRAC_BITS = 10;

    localparam int DATA_W  = 32;
    localparam int ERR_W   = 33;
    localparam int RATE_W  = 34;
    localparam int ALPHA_W = 11;
    localparam int LIM_W   = 31;
    localparam int PROD_W  = 66;
    localparam int ACC_W   = 68;
    localparam int ADDR_W  = 5;

    typedef enum logic [2:0] {
        REG_KP,
        REG_KI,
        REG_KD,
        REG_ALPHA,
        REG_IMAX,
        REG_IMIN,
        REG_OMAX,
        REG_OMIN
    } t_reg_idx;

    typedef struct packed {
        logic signed [DATA_W-1:0] kp;
        logic signed [DATA_W-1:0] ki;
        logic signed [DATA_W-1:0] kd;
        logic [ALPHA_W-1:0]       alpha;
        logic [LIM_W-1:0]         imax;
        logic signed [DATA_W-1:0] imin;
        logic [LIM_W-1:0]         omax;
        logic signed [DATA_W-1:0] omin;
    } t_cfg;

    // operand pair fed to the shared multiplier
    typedef enum logic [2:0] {
        MUL_DE_ALPHA,
        MUL_RATE_BETA,
        MUL_ERR_KP,
        MUL_INT_KI,
        MUL_RATE_KD
    } t_mul_sel;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_ROUND,
        ACC_SIGN
    } t_acc_op;

    typedef struct packed {
        logic     clear;
        logic     load_err;
        logic     step;
        logic     ld_rate;
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
    } t_ctrl;

endpackage

[sv/pid_filtered_derivative_core.sv]
// A request is accepted only in S_IDLE; its drive is registered into o_drive in S_OUT once the
// result register is free. No new request is taken until the sequencer is back in S_IDLE after
// five products on the single shared 34x32 multiplier and two rounding passes on the accumulator.
// Reset: synchronous, active low; clears configuration, error history, integral and
// filtered rate. Any configuration write also clears the three controller states.
module pid_filtered_derivative_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [pfd_pkg::DATA_W-1:0] i_setpoint,
    input  logic signed [pfd_pkg::DATA_W-1:0] i_measurement,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [pfd_pkg::DATA_W-1:0] o_drive,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pfd_pkg::ADDR_W-1:0]        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import pfd_pkg::*;

    // One-hot sequencer. Filter phase: two products, sum, round, restore sign.
    // Output phase: three products, sum, round, restore sign, clamp.
    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_FMUL0 = 13'b0000000000010,
        S_FMUL1 = 13'b0000000000100,
        S_FADD  = 13'b0000000001000,
        S_FRND  = 13'b0000000010000,
        S_FSGN  = 13'b0000000100000,
        S_PMUL  = 13'b0000001000000,
        S_IMUL  = 13'b0000010000000,
        S_DMUL  = 13'b0000100000000,
        S_DADD  = 13'b0001000000000,
        S_ORND  = 13'b0010000000000,
        S_OSGN  = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } t_state;

    t_state                   r_state;
    t_state                   n_state;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_drive;

    t_cfg                     w_cfg;
    t_ctrl                    w_ctrl;
    logic                     w_clear;
    logic                     w_accept;
    logic                     w_capture;
    logic signed [DATA_W-1:0] w_drive;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid & o_in_ready;
    // the result register frees up when empty or when its request is taken
    assign w_capture   = (r_state == S_OUT) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_drive     = r_drive;

    pfd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg),
        .o_clear (w_clear)
    );

    pfd_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_ctrl),
        .i_cfg         (w_cfg),
        .i_setpoint    (i_setpoint),
        .i_measurement (i_measurement),
        .o_drive       (w_drive)
    );

    // Drive the shared unit by state; the multiplier is registered, so each
    // accumulate consumes the product issued one state earlier.
    always_comb begin
        w_ctrl          = '0;
        w_ctrl.clear    = w_clear;
        w_ctrl.mul_sel  = MUL_DE_ALPHA;
        w_ctrl.acc_op   = ACC_HOLD;
        n_state         = r_state;
        unique case (r_state)
            S_IDLE: begin
                w_ctrl.load_err = w_accept;
                if (w_accept) begin
                    n_state = S_FMUL0;
                end
            end
            S_FMUL0: begin
                // advance error history and integral, start alpha * delta
                w_ctrl.step    = 1'b1;
                w_ctrl.mul_sel = MUL_DE_ALPHA;
                n_state        = S_FMUL1;
            end
            S_FMUL1: begin
                w_ctrl.mul_sel = MUL_RATE_BETA;
                w_ctrl.acc_op  = ACC_LOAD;
                n_state        = S_FADD;
            end
            S_FADD: begin
                w_ctrl.acc_op = ACC_ADD;
                n_state       = S_FRND;
            end
            S_FRND: begin
                w_ctrl.acc_op = ACC_ROUND;
                n_state       = S_FSGN;
            end
            S_FSGN: begin
                w_ctrl.acc_op = ACC_SIGN;
                n_state       = S_PMUL;
            end
            S_PMUL: begin
                // store the new filtered rate before kd uses it
                w_ctrl.ld_rate = 1'b1;
                w_ctrl.mul_sel = MUL_ERR_KP;
                n_state        = S_IMUL;
            end
            S_IMUL: begin
                w_ctrl.mul_sel = MUL_INT_KI;
                w_ctrl.acc_op  = ACC_LOAD;
                n_state        = S_DMUL;
            end
            S_DMUL: begin
                w_ctrl.mul_sel = MUL_RATE_KD;
                w_ctrl.acc_op  = ACC_ADD;
                n_state        = S_DADD;
            end
            S_DADD: begin
                w_ctrl.acc_op = ACC_ADD;
                n_state       = S_ORND;
            end
            S_ORND: begin
                w_ctrl.acc_op = ACC_ROUND;
                n_state       = S_OSGN;
            end
            S_OSGN: begin
                w_ctrl.acc_op = ACC_SIGN;
                n_state       = S_OUT;
            end
            S_OUT: begin
                // hold here while the previous drive still waits downstream
                if (w_capture) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_capture) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_capture) begin
            r_drive <= w_drive;
        end
    end

endmodule

[sv/pfd_cfg_regs.sv]
module pfd_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pfd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output pfd_pkg::t_cfg              o_cfg,
    output logic                       o_clear
);
    import pfd_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_write;

    assign pready  = 1'b1;
    assign w_idx   = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_write = psel & penable & pwrite;
    assign o_clear = w_write;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_write) begin
            unique case (w_idx)
                REG_KP:    r_cfg.kp    <= pwdata;
                REG_KI:    r_cfg.ki    <= pwdata;
                REG_KD:    r_cfg.kd    <= pwdata;
                REG_ALPHA: r_cfg.alpha <= pwdata[ALPHA_W-1:0];
                REG_IMAX:  r_cfg.imax  <= pwdata[LIM_W-1:0];
                REG_IMIN:  r_cfg.imin  <= pwdata;
                REG_OMAX:  r_cfg.omax  <= pwdata[LIM_W-1:0];
                REG_OMIN:  r_cfg.omin  <= pwdata;
                default:   r_cfg       <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_KP:    prdata = r_cfg.kp;
            REG_KI:    prdata = r_cfg.ki;
            REG_KD:    prdata = r_cfg.kd;
            REG_ALPHA: prdata = {{(32-ALPHA_W){1'b0}}, r_cfg.alpha};
            REG_IMAX:  prdata = {{(32-LIM_W){1'b0}}, r_cfg.imax};
            REG_IMIN:  prdata = r_cfg.imin;
            REG_OMAX:  prdata = {{(32-LIM_W){1'b0}}, r_cfg.omax};
            REG_OMIN:  prdata = r_cfg.omin;
            default:   prdata = '0;
        endcase
    end

endmodule

[sv/pfd_datapath.sv]
module pfd_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pfd_pkg::t_ctrl                    i_ctrl,
    input  pfd_pkg::t_cfg                     i_cfg,
    input  logic signed [pfd_pkg::DATA_W-1:0] i_setpoint,
    input  logic signed [pfd_pkg::DATA_W-1:0] i_measurement,
    output logic signed [pfd_pkg::DATA_W-1:0] o_drive
);
    import pfd_pkg::*;

    localparam logic [DATA_W-1:0] ONE32     = DATA_W'(1) << FRAC_BITS;
    localparam logic [ALPHA_W-1:0] ALPHA0   = '0;
    localparam logic [RATE_W-1:0] INTMAX34  = RATE_W'(32'h7FFF_FFFF);
    localparam logic [ACC_W-1:0]  INTMAX68  = ACC_W'(32'h7FFF_FFFF);
    localparam logic [ACC_W-1:0]  HALF      = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic [ACC_W-1:0]  HALF_P1   = HALF + ACC_W'(1);

    logic signed [ERR_W-1:0]  r_err;
    logic signed [ERR_W-1:0]  r_last_err;
    logic signed [DATA_W-1:0] r_int;
    logic signed [RATE_W-1:0] r_rate;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_neg;

    logic [DATA_W-1:0]        w_alpha32;
    logic [DATA_W-1:0]        w_a_eff;
    logic [DATA_W-1:0]        w_beta;
    logic signed [RATE_W-1:0] w_de;
    logic signed [RATE_W-1:0] w_imax;
    logic signed [RATE_W-1:0] w_imin;
    logic signed [RATE_W-1:0] w_isum;
    logic signed [RATE_W-1:0] w_inew;
    logic signed [ACC_W-1:0]  w_omax;
    logic signed [ACC_W-1:0]  w_omin;
    logic signed [RATE_W-1:0] w_mul_a;
    logic signed [DATA_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0] w_prod;
    logic [ACC_W-1:0]         w_shifted;
    logic signed [ERR_W-1:0]  w_err_in;

    // alpha of zero or above full scale means no filtering
    assign w_alpha32 = {{(DATA_W-ALPHA_W){1'b0}}, i_cfg.alpha};
    assign w_a_eff   = (i_cfg.alpha == ALPHA0 || w_alpha32 > ONE32) ? ONE32 : w_alpha32;
    assign w_beta    = ONE32 - w_a_eff;

    assign w_err_in = {i_setpoint[DATA_W-1], i_setpoint}
                    - {i_measurement[DATA_W-1], i_measurement};
    assign w_de     = {r_err[ERR_W-1], r_err} - {r_last_err[ERR_W-1], r_last_err};

    assign w_imax = (i_cfg.imax == '0) ? INTMAX34 : {{(RATE_W-LIM_W){1'b0}}, i_cfg.imax};
    assign w_imin = (i_cfg.imin == '0) ? -w_imax
                  : {{(RATE_W-DATA_W){i_cfg.imin[DATA_W-1]}}, i_cfg.imin};
    assign w_isum = {{(RATE_W-DATA_W){r_int[DATA_W-1]}}, r_int}
                  + {r_err[ERR_W-1], r_err};

    // when the limits cross, a sum above the upper bound takes it; any other sum takes the lower one
    always_comb begin
        priority if (w_isum > w_imax) begin
            w_inew = w_imax;
        end else if (w_isum < w_imin) begin
            w_inew = w_imin;
        end else begin
            w_inew = w_isum;
        end
    end

    always_comb begin
        unique case (i_ctrl.mul_sel)
            MUL_DE_ALPHA: begin
                w_mul_a = w_de;
                w_mul_b = w_a_eff;
            end
            MUL_RATE_BETA: begin
                w_mul_a = r_rate;
                w_mul_b = w_beta;
            end
            MUL_ERR_KP: begin
                w_mul_a = {r_err[ERR_W-1], r_err};
                w_mul_b = i_cfg.kp;
            end
            MUL_INT_KI: begin
                w_mul_a = {{(RATE_W-DATA_W){r_int[DATA_W-1]}}, r_int};
                w_mul_b = i_cfg.ki;
            end
            MUL_RATE_KD: begin
                w_mul_a = r_rate;
                w_mul_b = i_cfg.kd;
            end
            default: begin
                w_mul_a = r_rate;
                w_mul_b = i_cfg.kd;
            end
        endcase
    end

    assign w_prod    = w_mul_a * w_mul_b;
    assign w_shifted = r_acc >> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        unique case (i_ctrl.acc_op)
            ACC_HOLD: r_acc <= r_acc;
            ACC_LOAD: r_acc <= {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
            ACC_ADD:  r_acc <= r_acc + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
            ACC_ROUND: begin
                // magnitude plus half, negation folded into the same add
                r_neg <= r_acc[ACC_W-1];
                r_acc <= r_acc[ACC_W-1] ? (~r_acc + HALF_P1) : (r_acc + HALF);
            end
            ACC_SIGN: r_acc <= r_neg ? -w_shifted : w_shifted;
            default:  r_acc <= r_acc;
        endcase
        if (i_ctrl.load_err) begin
            r_err <= w_err_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_last_err <= '0;
            r_int      <= '0;
            r_rate     <= '0;
        end else begin
            if (i_ctrl.step) begin
                r_last_err <= r_err;
                r_int      <= w_inew[DATA_W-1:0];
            end
            if (i_ctrl.ld_rate) begin
                r_rate <= r_acc[RATE_W-1:0];
            end
        end
    end

    assign w_omax = (i_cfg.omax == '0) ? INTMAX68 : {{(ACC_W-LIM_W){1'b0}}, i_cfg.omax};
    assign w_omin = (i_cfg.omin == '0) ? -w_omax
                  : {{(ACC_W-DATA_W){i_cfg.omin[DATA_W-1]}}, i_cfg.omin};

    always_comb begin
        priority if (r_acc > w_omax) begin
            o_drive = w_omax[DATA_W-1:0];
        end else if (r_acc < w_omin) begin
            o_drive = w_omin[DATA_W-1:0];
        end else begin
            o_drive = r_acc[DATA_W-1:0];
        end
    end

endmodule
